/* src/msup_pkg.sv */
package msup_pkg;

  localparam int STATE_W       = 4;
  localparam int CAUSE_W       = 2;
  localparam int FAULT_CODE_W  = 5;
  localparam int FAULT_BITS_W  = 32;
  localparam int FAULT_CODES_DEF = 32;

  // Item kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_FAULT   = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  // Change causes
  localparam logic [CAUSE_W-1:0] CAUSE_INTERNAL = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_USER     = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_FAULT    = 2'd3;

  // Safety modes
  localparam logic [1:0] SAFETY_LOCAL_STOP   = 2'd1;
  localparam logic [1:0] SAFETY_GLOBAL_ESTOP = 2'd3;

  // Action codes
  localparam logic [1:0] PWM_NONE   = 2'd0;
  localparam logic [1:0] PWM_STOP   = 2'd1;
  localparam logic [1:0] PWM_START  = 2'd2;
  localparam logic [1:0] SENSOR_NONE = 2'd0;
  localparam logic [1:0] SENSOR_ON   = 2'd1;
  localparam logic [1:0] SENSOR_OFF  = 2'd2;

  // Report flag bit positions
  localparam int REP_STATE = 0;
  localparam int REP_HOMED = 1;
  localparam int REP_FAULT = 2;

  typedef enum logic [STATE_W-1:0] {
    S_FAULT      = 4'd0,
    S_ESTOP      = 4'd1,
    S_SAFESTOP   = 4'd2,
    S_STANDBY    = 4'd3,
    S_STARTUP    = 4'd4,
    S_SELFTEST   = 4'd5,
    S_FACTORYCAL = 4'd6,
    S_READY      = 4'd7,
    S_DIAG       = 4'd8,
    S_HOME       = 4'd9,
    S_BOOT       = 4'd10,
    S_MOTIONCAL  = 4'd11
  } ctrl_state_e;

  // Bit n set: a request for state n may leave the indexed current state.
  localparam logic [15:0] ALLOW_MASK [16] = '{
    16'h0009, 16'h0009, 16'h000B, 16'h0473, 16'hFFFF, 16'hFFFF, 16'h000F, 16'hFBFF,
    16'hFBFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
  };

  typedef struct packed {
    logic [1:0]              kind;
    logic [STATE_W-1:0]      requested_state;
    logic [CAUSE_W-1:0]      change_source;
    logic [FAULT_CODE_W-1:0] fault_code;
    logic                    pwm_start_ok;
  } in_item_t;

  typedef struct packed {
    logic                    accepted;
    logic [STATE_W-1:0]      control_state;
    logic [CAUSE_W-1:0]      change_cause;
    logic [FAULT_CODE_W-1:0] last_fault;
    logic [FAULT_BITS_W-1:0] fault_bits;
    logic [1:0]              pwm_command;
    logic [1:0]              sensor_power_cmd;
    logic                    fan_force_on;
    logic                    brake;
    logic                    current_limit_zero;
    logic                    enter_bootloader;
    logic [2:0]              report_flags;
  } out_item_t;

  typedef struct packed {
    logic               accepted;
    ctrl_state_e        state;
    logic [CAUSE_W-1:0] cause;
    logic [1:0]         pwm_cmd;
    logic [1:0]         sensor_cmd;
    logic               fan;
    logic               brake;
    logic               climit;
    logic               boot;
    logic [2:0]         report;
  } decision_t;

endpackage

/* src/msup_fault_latch.sv */
module msup_fault_latch #(
  parameter int FAULT_CODES = msup_pkg::FAULT_CODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [1:0]                          kind,
  input  logic [msup_pkg::FAULT_CODE_W-1:0]   fault_code,
  output logic                                fresh,
  output logic [msup_pkg::FAULT_BITS_W-1:0]   bits_out,
  output logic [msup_pkg::FAULT_CODE_W-1:0]   last_out
);
  import msup_pkg::*;

  localparam int IDX_W = (FAULT_CODES > 1) ? $clog2(FAULT_CODES) : 1;
  localparam logic [FAULT_CODE_W:0] CODE_LIMIT = (FAULT_CODE_W + 1)'(FAULT_CODES);

  logic [FAULT_CODES-1:0]  latch;
  logic [FAULT_CODES-1:0]  latch_next;
  logic [FAULT_CODE_W-1:0] last_fault;
  logic [FAULT_CODE_W-1:0] last_fault_next;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;

  assign idx      = fault_code[IDX_W-1:0];
  assign in_range = (fault_code != '0) && ({1'b0, fault_code} < CODE_LIMIT);
  assign fresh    = (kind == KIND_FAULT) && in_range && !latch[idx];

  always_comb begin
    latch_next      = latch;
    last_fault_next = last_fault;
    if (kind == KIND_CLEAR) begin
      latch_next      = '0;
      last_fault_next = '0;
    end else if (fresh) begin
      latch_next[idx] = 1'b1;
      last_fault_next = fault_code;
    end
  end

  assign bits_out = FAULT_BITS_W'(latch_next);
  assign last_out = last_fault_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      latch      <= '0;
      last_fault <= '0;
    end else if (take) begin
      latch      <= latch_next;
      last_fault <= last_fault_next;
    end
  end

endmodule

/* src/msup_decide.sv */
module msup_decide (
  input  msup_pkg::in_item_t              item,
  input  msup_pkg::ctrl_state_e           cur_state,
  input  logic [msup_pkg::CAUSE_W-1:0]    cur_cause,
  input  logic [1:0]                      safety_mode,
  input  logic                            fault_fresh,
  output msup_pkg::decision_t             dec
);
  import msup_pkg::*;

  logic [STATE_W-1:0] req;
  logic [CAUSE_W-1:0] src;
  logic               do_change;
  logic               stop_to_fault;

  // Fault vs. emergency stop judged on the state before the request
  assign stop_to_fault = (safety_mode == SAFETY_LOCAL_STOP) ||
                         (cur_state == S_STANDBY) || (cur_state == S_STARTUP);

  always_comb begin
    dec            = '0;
    dec.state      = cur_state;
    dec.cause      = cur_cause;
    dec.pwm_cmd    = PWM_NONE;
    dec.sensor_cmd = SENSOR_NONE;
    req            = item.requested_state;
    src            = item.change_source;
    do_change      = 1'b0;

    case (item.kind)
      KIND_REQUEST: begin
        do_change = 1'b1;
      end
      KIND_FAULT: begin
        if (item.fault_code != '0) begin
          req        = STATE_W'(S_FAULT);
          src        = CAUSE_FAULT;
          do_change  = 1'b1;
          dec.climit = 1'b1;
          if (fault_fresh) dec.report[REP_FAULT] = 1'b1;
        end
      end
      KIND_CLEAR: begin
        dec.report[REP_FAULT] = 1'b1;
      end
      default: ;
    endcase

    if (do_change) begin
      if (req == cur_state) begin
        dec.accepted = 1'b1;
      end else if (!ALLOW_MASK[cur_state][req]) begin
        dec.report[REP_STATE] = 1'b1;
      end else begin
        dec.accepted          = 1'b1;
        dec.report[REP_STATE] = 1'b1;
        case (req)
          S_SELFTEST, S_FACTORYCAL: begin
            if (cur_state == S_STANDBY) begin
              dec.cause             = src;
              dec.state             = ctrl_state_e'(req);
              dec.sensor_cmd        = SENSOR_ON;
              dec.pwm_cmd           = PWM_STOP;
              dec.fan               = 1'b1;
              dec.report[REP_HOMED] = 1'b1;
            end
          end
          S_STARTUP: begin
            dec.cause             = src;
            dec.state             = S_STARTUP;
            dec.pwm_cmd           = PWM_STOP;
            dec.report[REP_HOMED] = 1'b1;
          end
          S_STANDBY: begin
            dec.cause             = src;
            dec.state             = S_STANDBY;
            dec.pwm_cmd           = PWM_STOP;
            dec.sensor_cmd        = SENSOR_OFF;
            dec.report[REP_HOMED] = 1'b1;
          end
          S_SAFESTOP: begin
            dec.cause  = src;
            dec.state  = S_SAFESTOP;
            dec.climit = 1'b1;
            dec.brake  = 1'b1;
          end
          S_MOTIONCAL, S_DIAG, S_HOME: ;
          S_READY: begin
            if (src != CAUSE_USER) begin
              dec.cause      = src;
              dec.state      = S_READY;
              dec.sensor_cmd = SENSOR_ON;
              dec.pwm_cmd    = PWM_START;
              if (!item.pwm_start_ok) begin
                // only local stop mode faults here; any other mode goes to emergency stop
                dec.climit = 1'b1;
                if (safety_mode == SAFETY_LOCAL_STOP) begin
                  dec.state             = S_FAULT;
                  dec.pwm_cmd           = PWM_STOP;
                  dec.sensor_cmd        = SENSOR_OFF;
                  dec.report[REP_HOMED] = 1'b1;
                end else begin
                  dec.state = S_ESTOP;
                  dec.brake = 1'b1;
                end
              end
            end
          end
          S_ESTOP: begin
            dec.cause  = src;
            dec.state  = S_ESTOP;
            dec.climit = 1'b1;
            dec.brake  = 1'b1;
          end
          S_BOOT: begin
            dec.cause      = src;
            dec.state      = S_BOOT;
            dec.pwm_cmd    = PWM_STOP;
            dec.sensor_cmd = SENSOR_OFF;
            dec.boot       = 1'b1;
          end
          default: begin
            // fault request or unknown state code
            dec.cause  = src;
            dec.climit = 1'b1;
            if (stop_to_fault) begin
              dec.state             = S_FAULT;
              dec.pwm_cmd           = PWM_STOP;
              dec.sensor_cmd        = SENSOR_OFF;
              dec.report[REP_HOMED] = 1'b1;
            end else begin
              dec.state = S_ESTOP;
              dec.brake = 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

/* src/motor_control_state_supervisor.sv */
// Control-state supervisor for a motor drive. Each input beat is one event:
// a state change request with its cause, a fault report, or a clear of the
// fault latch; each gives exactly one result beat carrying the accept flag,
// the control state after the event, the recorded cause, the fault latch and
// the action commands for that event. Throughput is one beat per clock
// unless the result side stalls: a beat waits in the input register, where
// the transition table and entry rules decide its outcome, and the control
// state, cause and fault latch are written at the same edge that loads the
// result register, so the very next beat already sees them. The input side
// keeps taking beats while a result waits; it stops only when both the input
// and the result register are full. Fault codes at or above FAULT_CODES
// latch nothing. safety_mode resets to global emergency stop and is to be
// written only while the block is idle.
module motor_control_state_supervisor #(
  parameter int FAULT_CODES = msup_pkg::FAULT_CODES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  msup_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output msup_pkg::out_item_t result
);
  import msup_pkg::*;

  // configuration
  logic [1:0] safety_mode;

  // input stage
  logic     hold_valid;
  in_item_t hold_item;

  // supervisor state
  ctrl_state_e        ctrl_state;
  logic [CAUSE_W-1:0] cause_reg;

  // result stage
  logic      res_valid;
  out_item_t res_item;
  out_item_t res_next;

  logic                    advance;
  logic                    take;
  logic                    fault_fresh;
  logic [FAULT_BITS_W-1:0] fault_bits;
  logic [FAULT_CODE_W-1:0] last_fault;
  decision_t               dec;

  // result register frees when empty or being drained this cycle
  assign advance    = !res_valid || result_ready;
  assign take       = hold_valid && advance;
  assign item_ready = !hold_valid || advance;

  assign result_valid = res_valid;
  assign result       = res_item;

  msup_fault_latch #(
    .FAULT_CODES (FAULT_CODES)
  ) u_fault_latch (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .kind       (hold_item.kind),
    .fault_code (hold_item.fault_code),
    .fresh      (fault_fresh),
    .bits_out   (fault_bits),
    .last_out   (last_fault)
  );

  msup_decide u_decide (
    .item        (hold_item),
    .cur_state   (ctrl_state),
    .cur_cause   (cause_reg),
    .safety_mode (safety_mode),
    .fault_fresh (fault_fresh),
    .dec         (dec)
  );

  always_comb begin
    res_next.accepted           = dec.accepted;
    res_next.control_state      = dec.state;
    res_next.change_cause       = dec.cause;
    res_next.last_fault         = last_fault;
    res_next.fault_bits         = fault_bits;
    res_next.pwm_command        = dec.pwm_cmd;
    res_next.sensor_power_cmd   = dec.sensor_cmd;
    res_next.fan_force_on       = dec.fan;
    res_next.brake              = dec.brake;
    res_next.current_limit_zero = dec.climit;
    res_next.enter_bootloader   = dec.boot;
    res_next.report_flags       = dec.report;
  end

  // control: valid flags, state, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid  <= 1'b0;
      res_valid   <= 1'b0;
      ctrl_state  <= S_STANDBY;
      cause_reg   <= CAUSE_INTERNAL;
      safety_mode <= SAFETY_GLOBAL_ESTOP;
    end else begin
      if (cfg_wr_en) safety_mode <= cfg_wr_data;
      if (item_ready) hold_valid <= item_valid;
      if (advance) res_valid <= hold_valid;
      if (take) begin
        ctrl_state <= dec.state;
        cause_reg  <= dec.cause;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (item_ready && item_valid) hold_item <= item;
    if (take) res_item <= res_next;
  end

  // a refused request never moves the state
  assert property (@(posedge clk) disable iff (rst)
    take && hold_item.kind == KIND_REQUEST && !dec.accepted
    |=> ctrl_state == $past(ctrl_state))
    else $error("refused request changed control state");

  // a nonzero fault report always zeroes the current limit in its result
  assert property (@(posedge clk) disable iff (rst)
    take && hold_item.kind == KIND_FAULT && hold_item.fault_code != '0
    |=> res_valid && res_item.current_limit_zero)
    else $error("fault report without current limit zero");

  // a latch clear shows an empty latch in its result
  assert property (@(posedge clk) disable iff (rst)
    take && hold_item.kind == KIND_CLEAR
    |=> res_item.fault_bits == '0 && res_item.last_fault == '0)
    else $error("fault latch not cleared");

  // bootloader command only together with the bootloader state
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.enter_bootloader |-> res_item.control_state == S_BOOT)
    else $error("bootloader command outside bootloader state");

endmodule
